FILE: hw/rtl/fsei_pkg.sv
// Package for the free-space edge interval unit: field widths, side codes and
// the pipeline metadata types. No dependencies.
package fsei_pkg;

  localparam int COEF_W    = 48;
  localparam int QB_W      = 49;
  localparam int QC_W      = 50;
  localparam int NEGQB_W   = 50;
  localparam int LNUM_W    = 51;
  localparam int DEN_W     = 49;
  localparam int NUM_W     = 52;
  localparam int MUL_W     = 50;
  localparam int HALF_W    = 25;
  localparam int PROD_W    = 100;
  localparam int ROOT_W    = 50;
  localparam int REM_W     = 52;
  localparam int SQ_STAGES = 50;

  typedef enum logic [1:0] {
    SIDE_Y0 = 2'd0,
    SIDE_X1 = 2'd1,
    SIDE_Y1 = 2'd2,
    SIDE_X0 = 2'd3
  } side_e;

  typedef struct packed {
    logic qa_zero;
    logic qa_neg;
    logic qb_zero;
    logic qb_pos;
    logic qc_neg;
    logic qc_le0;
    logic t_le0;
    logic sdiff;
    logic dneg;
    logic dzero;
  } flags_t;

  typedef struct packed {
    flags_t                     fl;
    logic signed [NEGQB_W-1:0]  neg_qb;
    logic signed [DEN_W-1:0]    den;
    logic signed [LNUM_W-1:0]   lin_num;
  } meta_t;

endpackage

FILE: hw/rtl/free_space_edge_interval_unit.sv
// Free-space edge interval unit: restricts a conic to one cell side and
// solves qa*t^2 + qb*t + qc <= 0 over [0,1]. Depends on fsei_pkg.
// Throughput: one transaction per cycle unless the output stalls. The 50-stage
// square-root pipe and the FRAC_BITS+2 stage divider pipes give one bit per stage.
// The whole pipe advances when the output register is empty or taken.
// Reset clears only the valid bits; no clearing pass.
module free_space_edge_interval_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [fsei_pkg::COEF_W-1:0] coef_a_i,
  input  logic signed [fsei_pkg::COEF_W-1:0] coef_b_i,
  input  logic signed [fsei_pkg::COEF_W-1:0] coef_c_i,
  input  logic signed [fsei_pkg::COEF_W-1:0] coef_f_i,
  input  logic signed [fsei_pkg::COEF_W-1:0] coef_g_i,
  input  logic signed [fsei_pkg::COEF_W-1:0] coef_h_i,
  input  logic [1:0]                         side_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               found_o,
  output logic [FRAC_BITS:0]                 lower_o,
  output logic [FRAC_BITS:0]                 upper_o
);
  import fsei_pkg::*;

  localparam int DIV_STEPS = FRAC_BITS + 2;
  localparam int R_W       = FRAC_BITS + 3;
  localparam logic signed [R_W-1:0] ONE_FX = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [DIV_STEPS-1:0]  LIM_Q  = {1'b1, {(FRAC_BITS+1){1'b0}}};

  logic en;

  // stage 1: side selection
  logic                      v1_q;
  logic signed [COEF_W-1:0]  qa1_q;
  logic signed [QB_W-1:0]    qb1_q;
  logic signed [QC_W-1:0]    qc1_q;
  logic signed [COEF_W-1:0]  qa1_d;
  logic signed [QB_W-1:0]    qb1_d;
  logic signed [QC_W-1:0]    qc1_d;

  // stage 2: flags and magnitudes
  logic               v2_q;
  meta_t              m2_q, m2_d;
  logic [MUL_W-1:0]   amag2_q, bmag2_q, cmag2_q;
  logic [MUL_W-1:0]   amag2_d, bmag2_d, cmag2_d;
  logic signed [QC_W-1:0] tsum;

  // stage 3: partial products
  logic                  v3_q;
  meta_t                 m3_q;
  logic [2*HALF_W-1:0]   pb_ll_q, pb_lh_q, pb_hh_q;
  logic [2*HALF_W-1:0]   pq_ll_q, pq_lh_q, pq_hl_q, pq_hh_q;

  // stage 4: products
  logic                v4_q;
  meta_t               m4_q;
  logic [PROD_W-1:0]   p4_q, q4_q;

  // square-root pipe; index 0 is the discriminant stage
  logic               sq_v_q    [SQ_STAGES+1];
  meta_t              sq_meta_q [SQ_STAGES+1];
  logic [PROD_W-1:0]  sq_x_q    [SQ_STAGES+1];
  logic [REM_W-1:0]   sq_rem_q  [SQ_STAGES+1];
  logic [ROOT_W-1:0]  sq_root_q [SQ_STAGES+1];
  meta_t              m5_d;
  logic [PROD_W-1:0]  disc_d, qq4;

  // numerators
  logic                      vp1_q;
  flags_t                    fl_p1_q;
  logic signed [NUM_W-1:0]   num_p1_q [2];
  logic signed [DEN_W-1:0]   den_p1_q;
  logic signed [NUM_W-1:0]   num_p1_d [2];

  // magnitudes
  logic                vp2_q;
  flags_t              fl_p2_q;
  logic [NUM_W-1:0]    nm_p2_q [2];
  logic                neg_p2_q [2];
  logic [DEN_W-1:0]    dm_p2_q;

  // divider pipes; index 0 is the setup stage
  logic                  div_v_q   [DIV_STEPS+1];
  flags_t                div_fl_q  [DIV_STEPS+1];
  logic [DEN_W-1:0]      div_dm_q  [DIV_STEPS+1];
  logic [DEN_W-1:0]      div_rem_q [DIV_STEPS+1][2];
  logic [DIV_STEPS-1:0]  div_quo_q [DIV_STEPS+1][2];
  logic [1:0]            div_lo_q  [DIV_STEPS+1][2];
  logic                  div_sat_q [DIV_STEPS+1][2];
  logic                  div_neg_q [DIV_STEPS+1][2];

  // ratio finish
  logic                  vf1_q;
  flags_t                fl_f1_q;
  logic signed [R_W-1:0] r_f1_q [2];
  logic signed [R_W-1:0] r_f1_d [2];

  // output register
  logic               out_valid_q, found_q;
  logic [FRAC_BITS:0] lower_q, upper_q;
  logic               found_d;
  logic signed [R_W-1:0] lo_d, hi_d, r1, r2;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign lower_o     = lower_q;
  assign upper_o     = upper_q;

  always_comb begin
    unique case (side_e'(side_i))
      SIDE_Y0: begin
        qa1_d = coef_a_i;
        qb1_d = QB_W'(coef_f_i);
        qc1_d = QC_W'(coef_h_i);
      end
      SIDE_X1: begin
        qa1_d = coef_c_i;
        qb1_d = QB_W'(coef_b_i) + QB_W'(coef_g_i);
        qc1_d = QC_W'(coef_a_i) + QC_W'(coef_f_i) + QC_W'(coef_h_i);
      end
      SIDE_Y1: begin
        qa1_d = coef_a_i;
        qb1_d = QB_W'(coef_f_i) + QB_W'(coef_b_i);
        qc1_d = QC_W'(coef_c_i) + QC_W'(coef_g_i) + QC_W'(coef_h_i);
      end
      default: begin
        qa1_d = coef_c_i;
        qb1_d = QB_W'(coef_g_i);
        qc1_d = QC_W'(coef_h_i);
      end
    endcase
  end

  always_comb begin
    tsum             = QC_W'(qa1_q) + QC_W'(qb1_q);
    m2_d             = '0;
    m2_d.fl.qa_zero  = (qa1_q == '0);
    m2_d.fl.qa_neg   = qa1_q[COEF_W-1];
    m2_d.fl.qb_zero  = (qb1_q == '0);
    m2_d.fl.qb_pos   = !qb1_q[QB_W-1] && (qb1_q != '0);
    m2_d.fl.qc_neg   = qc1_q[QC_W-1];
    m2_d.fl.qc_le0   = qc1_q[QC_W-1] || (qc1_q == '0);
    m2_d.fl.t_le0    = (qc1_q == '0) ? (tsum[QC_W-1] || (tsum == '0)) : qc1_q[QC_W-1];
    m2_d.fl.sdiff    = qa1_q[COEF_W-1] != qc1_q[QC_W-1];
    m2_d.neg_qb      = -NEGQB_W'(qb1_q);
    m2_d.den         = (qa1_q == '0) ? qb1_q : {qa1_q, 1'b0};
    m2_d.lin_num     = -LNUM_W'(qc1_q);
    amag2_d = qa1_q[COEF_W-1] ? MUL_W'(-MUL_W'(qa1_q)) : MUL_W'(qa1_q);
    bmag2_d = qb1_q[QB_W-1]   ? MUL_W'(-MUL_W'(qb1_q)) : MUL_W'(qb1_q);
    cmag2_d = qc1_q[QC_W-1]   ? MUL_W'(-qc1_q)         : MUL_W'(qc1_q);
  end

  always_comb begin
    qq4  = p4_q;
    m5_d = m4_q;
    qq4  = q4_q << 2;
    if (m4_q.fl.sdiff) begin
      disc_d        = p4_q + qq4;
      m5_d.fl.dneg  = 1'b0;
      m5_d.fl.dzero = (p4_q == '0) && (q4_q == '0);
    end else begin
      m5_d.fl.dneg  = p4_q < qq4;
      m5_d.fl.dzero = p4_q == qq4;
      disc_d        = (p4_q < qq4) ? (qq4 - p4_q) : (p4_q - qq4);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      sq_v_q[0]   <= 1'b0;
      vp1_q       <= 1'b0;
      vp2_q       <= 1'b0;
      div_v_q[0]  <= 1'b0;
      vf1_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      sq_v_q[0]   <= v4_q;
      vp1_q       <= sq_v_q[SQ_STAGES];
      vp2_q       <= vp1_q;
      div_v_q[0]  <= vp2_q;
      vf1_q       <= div_v_q[DIV_STEPS];
      out_valid_q <= vf1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qa1_q   <= qa1_d;
      qb1_q   <= qb1_d;
      qc1_q   <= qc1_d;
      m2_q    <= m2_d;
      amag2_q <= amag2_d;
      bmag2_q <= bmag2_d;
      cmag2_q <= cmag2_d;
      m3_q    <= m2_q;
      pb_ll_q <= bmag2_q[HALF_W-1:0] * bmag2_q[HALF_W-1:0];
      pb_lh_q <= bmag2_q[HALF_W-1:0] * bmag2_q[MUL_W-1:HALF_W];
      pb_hh_q <= bmag2_q[MUL_W-1:HALF_W] * bmag2_q[MUL_W-1:HALF_W];
      pq_ll_q <= amag2_q[HALF_W-1:0] * cmag2_q[HALF_W-1:0];
      pq_lh_q <= amag2_q[HALF_W-1:0] * cmag2_q[MUL_W-1:HALF_W];
      pq_hl_q <= amag2_q[MUL_W-1:HALF_W] * cmag2_q[HALF_W-1:0];
      pq_hh_q <= amag2_q[MUL_W-1:HALF_W] * cmag2_q[MUL_W-1:HALF_W];
      m4_q    <= m3_q;
      p4_q    <= (PROD_W'(pb_hh_q) << (2*HALF_W)) + (PROD_W'(pb_lh_q) << (HALF_W+1))
                 + PROD_W'(pb_ll_q);
      q4_q    <= (PROD_W'(pq_hh_q) << (2*HALF_W))
                 + ((PROD_W'(pq_lh_q) + PROD_W'(pq_hl_q)) << HALF_W) + PROD_W'(pq_ll_q);
      sq_meta_q[0] <= m5_d;
      sq_x_q[0]    <= disc_d;
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam int P = SQ_STAGES - 1 - k;
    logic [REM_W+1:0] sh, trial;
    logic             ge;
    always_comb begin
      sh    = {sq_rem_q[k], sq_x_q[k][2*P+1 -: 2]};
      trial = {2'b00, sq_root_q[k], 2'b01};
      ge    = sh >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_meta_q[k+1] <= sq_meta_q[k];
        sq_x_q[k+1]    <= sq_x_q[k];
        sq_rem_q[k+1]  <= ge ? REM_W'(sh - trial) : REM_W'(sh);
        sq_root_q[k+1] <= {sq_root_q[k][ROOT_W-2:0], ge};
      end
    end
  end

  always_comb begin
    logic signed [NUM_W-1:0] sx, nqb;
    meta_t                   m;
    m   = sq_meta_q[SQ_STAGES];
    sx  = $signed({2'b00, sq_root_q[SQ_STAGES]});
    nqb = NUM_W'(m.neg_qb);
    if (m.fl.qa_zero) begin
      num_p1_d[0] = NUM_W'(m.lin_num);
    end else if (m.fl.dzero) begin
      num_p1_d[0] = nqb;
    end else begin
      num_p1_d[0] = nqb - sx;
    end
    num_p1_d[1] = nqb + sx;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_p1_q     <= sq_meta_q[SQ_STAGES].fl;
      den_p1_q    <= sq_meta_q[SQ_STAGES].den;
      num_p1_q[0] <= num_p1_d[0];
      num_p1_q[1] <= num_p1_d[1];
      fl_p2_q     <= fl_p1_q;
      dm_p2_q     <= den_p1_q[DEN_W-1] ? DEN_W'(-den_p1_q) : DEN_W'(den_p1_q);
      div_fl_q[0] <= fl_p2_q;
      div_dm_q[0] <= dm_p2_q;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en) begin
        nm_p2_q[l]      <= num_p1_q[l][NUM_W-1] ? NUM_W'(-num_p1_q[l]) : NUM_W'(num_p1_q[l]);
        neg_p2_q[l]     <= num_p1_q[l][NUM_W-1] ^ den_p1_q[DEN_W-1];
        div_sat_q[0][l] <= nm_p2_q[l] >= {1'b0, dm_p2_q, 2'b00};
        div_rem_q[0][l] <= DEN_W'(nm_p2_q[l] >> 2);
        div_lo_q[0][l]  <= nm_p2_q[l][1:0];
        div_neg_q[0][l] <= neg_p2_q[l];
        div_quo_q[0][l] <= '0;
      end
    end

    always_comb begin
      logic [DIV_STEPS-1:0] rm;
      rm = (div_sat_q[DIV_STEPS][l] || (div_quo_q[DIV_STEPS][l] > LIM_Q))
           ? LIM_Q : div_quo_q[DIV_STEPS][l];
      r_f1_d[l] = div_neg_q[DIV_STEPS][l] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[j+1] <= 1'b0;
      end else if (en) begin
        div_v_q[j+1] <= div_v_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_fl_q[j+1] <= div_fl_q[j];
        div_dm_q[j+1] <= div_dm_q[j];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_dl
      logic             b, ge;
      logic [DEN_W:0]   sh;
      always_comb begin
        if (j == 0) begin
          b = div_lo_q[j][l][1];
        end else if (j == 1) begin
          b = div_lo_q[j][l][0];
        end else begin
          b = 1'b0;
        end
        sh = {div_rem_q[j][l], b};
        ge = sh >= {1'b0, div_dm_q[j]};
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          div_rem_q[j+1][l] <= ge ? DEN_W'(sh - {1'b0, div_dm_q[j]}) : DEN_W'(sh);
          div_quo_q[j+1][l] <= {div_quo_q[j][l][DIV_STEPS-2:0], ge};
          div_lo_q[j+1][l]  <= div_lo_q[j][l];
          div_sat_q[j+1][l] <= div_sat_q[j][l];
          div_neg_q[j+1][l] <= div_neg_q[j][l];
        end
      end
    end
  end

  always_comb begin
    found_d = 1'b1;
    lo_d    = '0;
    hi_d    = ONE_FX;
    if (r_f1_q[0] > r_f1_q[1]) begin
      r1 = r_f1_q[1];
      r2 = r_f1_q[0];
    end else begin
      r1 = r_f1_q[0];
      r2 = r_f1_q[1];
    end
    if (fl_f1_q.qa_zero) begin
      if (fl_f1_q.qb_zero) begin
        found_d = fl_f1_q.qc_le0;
      end else if (fl_f1_q.qb_pos) begin
        if (r_f1_q[0] < 0) found_d = 1'b0;
        else if (r_f1_q[0] <= ONE_FX) hi_d = r_f1_q[0];
      end else begin
        if (r_f1_q[0] > ONE_FX) found_d = 1'b0;
        else if (r_f1_q[0] >= 0) lo_d = r_f1_q[0];
      end
    end else if (fl_f1_q.dneg) begin
      found_d = fl_f1_q.qc_neg;
    end else if (fl_f1_q.dzero) begin
      if (!fl_f1_q.t_le0) begin
        if (r_f1_q[0] < 0 || r_f1_q[0] > ONE_FX) begin
          found_d = 1'b0;
        end else begin
          lo_d = r_f1_q[0];
          hi_d = r_f1_q[0];
        end
      end
    end else if (fl_f1_q.qa_neg) begin
      if (r1 < 0) begin
        if (r2 > ONE_FX) found_d = 1'b0;
        else if (r2 > 0) lo_d = r2;
      end else if (!(r1 > ONE_FX || r2 <= ONE_FX)) begin
        hi_d = r1;
      end
    end else begin
      if (r2 < 0 || r1 > ONE_FX) begin
        found_d = 1'b0;
      end else begin
        if (r1 > 0) lo_d = r1;
        if (r2 < ONE_FX) hi_d = r2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_f1_q   <= div_fl_q[DIV_STEPS];
      r_f1_q[0] <= r_f1_d[0];
      r_f1_q[1] <= r_f1_d[1];
      found_q   <= found_d;
      lower_q   <= found_d ? lo_d[FRAC_BITS:0] : '0;
      upper_q   <= found_d ? hi_d[FRAC_BITS:0] : '0;
    end
  end

`ifndef ASSERT_OFF
  a_none_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> lower_o == '0 && upper_o == '0)
    else $error("empty interval with nonzero bounds");

  a_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> lower_o <= upper_o && upper_o <= ONE_FX[FRAC_BITS:0])
    else $error("interval bounds out of order or range");

  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted transaction lost at pipe entry");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vf1_q) && $stable(div_v_q[0]))
    else $error("pipe moved during stall");
`endif

endmodule
